@@ rtl/core/ndle_pkg.sv @@
// Package for the neighbor discovery / leader election core.
// Shared widths, codes, reset values and controller/datapath interface structs.
// No dependencies.
package ndle_pkg;

  localparam int TableDepthDefault = 32;

  localparam int AddrW     = 64;
  localparam int IntervalW = 16;
  localparam int TimeoutW  = 20;
  localparam int LfsrW     = 10;
  localparam int PingCntW  = 17;
  localparam int CountW    = 6;
  localparam int CfgIdxW   = 2;
  localparam int ProdW     = LfsrW + IntervalW;

  localparam logic [IntervalW-1:0] IntervalReset = 16'd1000;
  localparam logic [TimeoutW-1:0]  TimeoutReset  = 20'd50000;
  localparam logic [LfsrW-1:0]     LfsrReset     = 10'd1;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_OWN_ADDR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTERVAL = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT  = 2'd2;

  localparam logic EV_PING = 1'b0;
  localparam logic EV_END  = 1'b1;

  typedef struct packed {
    logic latch;
    logic mul;
    logic start_set;
    logic ping_set;
    logic tick;
    logic scan;
    logic update;
    logic load;
    logic load_event;
    logic load_last;
  } ndle_cmd_t;

  typedef struct packed {
    logic active;
    logic ping_due;
    logic end_due;
    logic end_hit;
    logic scan_done;
    logic out_free;
  } ndle_status_t;

endpackage

@@ rtl/core/neighbor_discovery_leader_election_core.sv @@
// Neighbor discovery with max-address leader election, top level.
// One item at a time. Start: multiply, then set. Received ping: serial scan, one stored
// address per cycle through the RAM read port, then update. Tick: ignored while inactive,
// else a countdown step, then a ping (multiply, set, emit) and/or a phase-end emit; emits
// wait on output stall. Unused kind: ignored. Results leave through an output register.
// Synchronous active-high reset; the table is not cleared, only filled entries are read.
module neighbor_discovery_leader_election_core import ndle_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [AddrW-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [AddrW-1:0]   leader_addr,
  input  logic [AddrW-1:0]   sender_addr,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               event_res,
  output logic [AddrW-1:0]   ping_leader,
  output logic [CountW-1:0]  neighbor_count,
  output logic               overflow,
  output logic               last
);

  ndle_cmd_t    cmd;
  ndle_status_t st;

  ndle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .st       (st),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  ndle_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .leader_addr    (leader_addr),
    .sender_addr    (sender_addr),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_valid),
    .event_res      (event_res),
    .ping_leader    (ping_leader),
    .neighbor_count (neighbor_count),
    .overflow       (overflow),
    .last           (last)
  );

endmodule

@@ rtl/core/ndle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ndle_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/ndle_ctrl.sv @@
// Controller state machine: sequences start, receive scan and tick handling.
// Depends on ndle_pkg for command/status structs and input kind codes.
module ndle_ctrl import ndle_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [1:0]   kind,
  input  ndle_status_t st,
  output logic         in_stall,
  output ndle_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_MUL,
    S_START_SET,
    S_SCAN,
    S_UPDATE,
    S_TICK,
    S_PING_MUL,
    S_PING_SET,
    S_EMIT_PING,
    S_EMIT_END
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (kind == KIND_START) begin
              state <= S_START_MUL;
            end else if (kind == KIND_PING) begin
              state <= S_SCAN;
            end else if (kind == KIND_TICK && st.active) begin
              state <= S_TICK;
            end
          end
        end
        S_START_MUL: state <= S_START_SET;
        S_START_SET: state <= S_IDLE;
        S_SCAN: begin
          if (st.scan_done) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: state <= S_IDLE;
        S_TICK: begin
          if (st.ping_due) begin
            state <= S_PING_MUL;
          end else if (st.end_due) begin
            state <= S_EMIT_END;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PING_MUL: state <= S_PING_SET;
        S_PING_SET: state <= S_EMIT_PING;
        S_EMIT_PING: begin
          if (st.out_free) begin
            state <= st.end_hit ? S_EMIT_END : S_IDLE;
          end
        end
        S_EMIT_END: begin
          if (st.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:      cmd.latch = in_valid;
      S_START_MUL: cmd.mul = 1'b1;
      S_START_SET: cmd.start_set = 1'b1;
      S_SCAN:      cmd.scan = 1'b1;
      S_UPDATE:    cmd.update = 1'b1;
      S_TICK:      cmd.tick = 1'b1;
      S_PING_MUL:  cmd.mul = 1'b1;
      S_PING_SET:  cmd.ping_set = 1'b1;
      S_EMIT_PING: begin
        cmd.load       = st.out_free;
        cmd.load_event = EV_PING;
        cmd.load_last  = !st.end_hit;
      end
      S_EMIT_END: begin
        cmd.load       = st.out_free;
        cmd.load_event = EV_END;
        cmd.load_last  = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/ndle_dp.sv @@
// Datapath: config registers, neighbor table scan, leader, countdowns,
// jitter LFSR and multiplier, output register. Depends on ndle_pkg, ndle_ram.
module ndle_dp import ndle_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [AddrW-1:0]   cfg_data,
  input  logic [AddrW-1:0]   leader_addr,
  input  logic [AddrW-1:0]   sender_addr,
  input  logic               out_stall,
  input  ndle_cmd_t          cmd,
  output ndle_status_t       st,
  output logic               out_valid,
  output logic               event_res,
  output logic [AddrW-1:0]   ping_leader,
  output logic [CountW-1:0]  neighbor_count,
  output logic               overflow,
  output logic               last
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int FW = $clog2(TABLE_DEPTH + 1);

  logic [AddrW-1:0]     own_address;
  logic [IntervalW-1:0] ping_interval;
  logic [TimeoutW-1:0]  end_timeout;

  logic [AddrW-1:0]     lead_in;
  logic [AddrW-1:0]     snd_in;
  logic [AddrW-1:0]     leader;
  logic [FW-1:0]        fill;
  logic [FW-1:0]        idx;
  logic                 rd_v;
  logic                 found;
  logic                 overflow_flag;
  logic                 phase_active;
  logic [PingCntW-1:0]  ping_countdown;
  logic [TimeoutW-1:0]  end_countdown;
  logic [LfsrW-1:0]     lfsr;
  logic [LfsrW-1:0]     lfsr_next;
  logic [ProdW-1:0]     prod;
  logic [IntervalW-1:0] jitter;
  logic                 end_hit;

  logic                 tbl_we;
  logic                 tbl_re;
  logic [AddrW-1:0]     tbl_rdata;
  logic                 table_full;
  logic                 hit_now;
  logic                 found_all;

  assign lfsr_next  = {lfsr[LfsrW-2:0], lfsr[9] ^ lfsr[6]};
  assign jitter     = prod[ProdW-1:LfsrW];
  assign table_full = (fill == FW'(TABLE_DEPTH));
  assign hit_now    = rd_v && (tbl_rdata == snd_in);
  assign found_all  = found || hit_now;
  assign tbl_re     = cmd.scan && (idx != fill);
  assign tbl_we     = cmd.update && !found_all && !table_full;

  ndle_ram #(
    .WIDTH (AddrW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (fill[AW-1:0]),
    .wdata (snd_in),
    .re    (tbl_re),
    .raddr (idx[AW-1:0]),
    .rdata (tbl_rdata)
  );

  assign st.active    = phase_active;
  assign st.ping_due  = (ping_countdown <= PingCntW'(1));
  assign st.end_due   = (end_countdown <= TimeoutW'(1));
  assign st.end_hit   = end_hit;
  assign st.scan_done = (idx == fill) && !rd_v;
  assign st.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address   <= '0;
      ping_interval <= IntervalReset;
      end_timeout   <= TimeoutReset;
    end else if (cfg_we) begin
      if (cfg_index == CFG_OWN_ADDR) begin
        own_address <= cfg_data;
      end else if (cfg_index == CFG_INTERVAL) begin
        ping_interval <= cfg_data[IntervalW-1:0];
      end else if (cfg_index == CFG_TIMEOUT) begin
        end_timeout <= cfg_data[TimeoutW-1:0];
      end
    end
  end

  // item capture, multiplier and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lead_in <= leader_addr;
      snd_in  <= sender_addr;
    end
    if (cmd.mul) begin
      prod <= ProdW'(lfsr) * ProdW'(ping_interval);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      rd_v  <= 1'b0;
      found <= 1'b0;
    end else if (cmd.latch) begin
      idx   <= '0;
      rd_v  <= 1'b0;
      found <= 1'b0;
    end else if (cmd.scan) begin
      rd_v  <= tbl_re;
      found <= found_all;
      if (tbl_re) begin
        idx <= idx + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leader         <= '0;
      fill           <= '0;
      overflow_flag  <= 1'b0;
      phase_active   <= 1'b0;
      ping_countdown <= '0;
      end_countdown  <= '0;
      lfsr           <= LfsrReset;
      end_hit        <= 1'b0;
    end else if (cmd.start_set) begin
      leader         <= own_address;
      ping_countdown <= PingCntW'(jitter);
      end_countdown  <= end_timeout;
      phase_active   <= 1'b1;
      lfsr           <= lfsr_next;
    end else if (cmd.ping_set) begin
      ping_countdown <= PingCntW'(ping_interval) + PingCntW'(jitter);
      lfsr           <= lfsr_next;
    end else if (cmd.update) begin
      if (!found_all) begin
        if (!table_full) begin
          fill <= fill + FW'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end
      if (leader < lead_in) begin
        leader <= lead_in;
      end
      if (phase_active && ((!found_all && !table_full) || (leader < lead_in))) begin
        end_countdown <= end_timeout;
      end
    end else if (cmd.tick) begin
      end_hit  <= st.end_due;
      if (!st.ping_due) begin
        ping_countdown <= ping_countdown - PingCntW'(1);
      end
      if (st.end_due) begin
        end_countdown <= '0;
        phase_active  <= 1'b0;
      end else begin
        end_countdown <= end_countdown - TimeoutW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      event_res      <= cmd.load_event;
      ping_leader    <= leader;
      neighbor_count <= CountW'(fill);
      overflow       <= overflow_flag;
      last           <= cmd.load_last;
    end
  end

endmodule

@@ rtl/core/ndle_checker.sv @@
// Port-level checker for the neighbor discovery core, with its bind.
// Depends on ndle_pkg and the top level's ports.
module ndle_checker import ndle_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               event_res,
  input logic [AddrW-1:0]   ping_leader,
  input logic [CountW-1:0]  neighbor_count,
  input logic               overflow,
  input logic               last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(ping_leader)
      && $stable(neighbor_count) && $stable(overflow) && $stable(last))
    else $error("stalled result changed");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_END |-> last)
    else $error("phase-end result without last");

  a_ping_then_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && event_res == EV_PING && !last
      |=> out_valid && event_res == EV_END && last)
    else $error("ping without last not followed by phase end");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind neighbor_discovery_leader_election_core ndle_checker u_ndle_checker (.*);

@@ verif/tb_neighbor_discovery_leader_election_core.sv @@
// Self-checking testbench for neighbor_discovery_leader_election_core.
// Drives start, ping, tick and unused-kind transfers with random idling on both sides and checks
// every ping and phase-end notice against an in-bench model. Depends on ndle_pkg.
`timescale 1ns / 1ps

module tb_neighbor_discovery_leader_election_core;
  import ndle_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int PoolSize    = 24;
  localparam int SettleTicks = 60;
  localparam int QuietLimit  = 5000;
  localparam int ItemTarget  = 2000;

  typedef struct packed {
    logic [1:0]       kind;
    logic [AddrW-1:0] lead;
    logic [AddrW-1:0] snd;
  } nd_msg_t;

  typedef struct packed {
    logic              ev;
    logic [AddrW-1:0]  leader;
    logic [CountW-1:0] count;
    logic              ovf;
    logic              last;
  } notice_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_OWN_ADDR;
  logic [AddrW-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         kind = KIND_TICK;
  logic [AddrW-1:0]   leader_addr = '0;
  logic [AddrW-1:0]   sender_addr = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               event_res;
  logic [AddrW-1:0]   ping_leader;
  logic [CountW-1:0]  neighbor_count;
  logic               overflow;
  logic               last;

  neighbor_discovery_leader_election_core uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .leader_addr(leader_addr), .sender_addr(sender_addr),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_res(event_res), .ping_leader(ping_leader),
    .neighbor_count(neighbor_count), .overflow(overflow), .last(last)
  );

  always #5 clk = ~clk;

  // node model state
  logic [AddrW-1:0]     own_cfg  = '0;
  logic [IntervalW-1:0] ival_cfg = IntervalReset;
  logic [TimeoutW-1:0]  tmo_cfg  = TimeoutReset;
  logic [AddrW-1:0]     known_nb [TableDepthDefault];
  int                   nb_fill  = 0;
  logic [AddrW-1:0]     cur_leader = '0;
  logic [PingCntW-1:0]  ping_cd  = '0;
  logic [TimeoutW-1:0]  end_cd   = '0;
  logic                 in_phase = 1'b0;
  logic                 nb_ovf   = 1'b0;
  logic [LfsrW-1:0]     jit_lfsr = LfsrReset;

  nd_msg_t   queued_msgs[$];
  notice_t   awaited_notices[$];
  nd_msg_t   cur_msg;
  logic [AddrW-1:0] sender_pool [PoolSize];

  int  cyc = 0;
  int  quiet = 0;
  int  n_items = 0;
  int  n_in = 0;
  int  n_pings = 0;
  int  n_ends = 0;
  int  err_count = 0;
  logic calm;

  assign calm = (cyc >= 4000) && (cyc < 9000);

  function automatic logic [AddrW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IntervalW-1:0] draw_jitter();
    logic [ProdW-1:0] prod;
    prod = {{IntervalW{1'b0}}, jit_lfsr} * {{LfsrW{1'b0}}, ival_cfg};
    jit_lfsr = {jit_lfsr[LfsrW-2:0], jit_lfsr[9] ^ jit_lfsr[6]};
    return prod[ProdW-1:LfsrW];
  endfunction

  function automatic notice_t make_notice(input logic ev, input logic is_last);
    notice_t nt;
    nt.ev = ev;
    nt.leader = cur_leader;
    nt.count = CountW'(nb_fill);
    nt.ovf = nb_ovf;
    nt.last = is_last;
    return nt;
  endfunction

  // advance the node by one accepted transfer and queue the notices it raises
  task automatic elect_step(input nd_msg_t m);
    logic hit;
    logic changed;
    logic ping_fire;
    logic end_fire;
    case (m.kind)
      KIND_START: begin
        cur_leader = own_cfg;
        ping_cd = {1'b0, draw_jitter()};
        end_cd = tmo_cfg;
        in_phase = 1'b1;
      end
      KIND_PING: begin
        hit = 1'b0;
        changed = 1'b0;
        for (int i = 0; i < nb_fill; i++)
          if (known_nb[i] == m.snd) hit = 1'b1;
        if (!hit) begin
          if (nb_fill < TableDepthDefault) begin
            known_nb[nb_fill] = m.snd;
            nb_fill++;
            changed = 1'b1;
          end else begin
            nb_ovf = 1'b1;
          end
        end
        if (cur_leader < m.lead) begin
          cur_leader = m.lead;
          changed = 1'b1;
        end
        if (changed && in_phase) end_cd = tmo_cfg;
      end
      KIND_TICK: begin
        if (in_phase) begin
          ping_fire = (ping_cd <= 1);
          end_fire = (end_cd <= 1);
          if (ping_fire) begin
            awaited_notices.push_back(make_notice(EV_PING, !end_fire));
            ping_cd = {1'b0, ival_cfg} + {1'b0, draw_jitter()};
          end else begin
            ping_cd = ping_cd - 1'b1;
          end
          if (end_fire) begin
            end_cd = '0;
            in_phase = 1'b0;
            awaited_notices.push_back(make_notice(EV_END, 1'b1));
          end else begin
            end_cd = end_cd - 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_msg(input logic [1:0] k, input logic [AddrW-1:0] lead,
                         input logic [AddrW-1:0] snd);
    nd_msg_t m;
    m.kind = k;
    m.lead = lead;
    m.snd = snd;
    queued_msgs.push_back(m);
    if (k != KIND_UNUSED) n_items++;
  endtask

  task automatic set_regs(input logic [AddrW-1:0] own, input logic [IntervalW-1:0] iv,
                          input logic [TimeoutW-1:0] tmo);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_OWN_ADDR;
    cfg_data <= own;
    @(posedge clk);
    cfg_index <= CFG_INTERVAL;
    cfg_data <= {{(AddrW-IntervalW){1'b0}}, iv};
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_data <= {{(AddrW-TimeoutW){1'b0}}, tmo};
    @(posedge clk);
    cfg_we <= 1'b0;
    own_cfg = own;
    ival_cfg = iv;
    tmo_cfg = tmo;
  endtask

  // wait for every queued transfer and notice, then let the core settle
  task automatic drain_all();
    while (queued_msgs.size() != 0 || in_valid || awaited_notices.size() != 0)
      @(posedge clk);
    repeat (SettleTicks) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        elect_step(cur_msg);
        n_in++;
      end
      if (!in_valid || !in_stall) begin
        if (queued_msgs.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
          cur_msg = queued_msgs.pop_front();
          in_valid <= 1'b1;
          kind <= cur_msg.kind;
          leader_addr <= cur_msg.lead;
          sender_addr <= cur_msg.snd;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin : mon
    notice_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_notices.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected notice: ev=%0b leader=%h cnt=%0d ovf=%0b last=%0b",
                     event_res, ping_leader, neighbor_count, overflow, last);
        end else begin
          want = awaited_notices.pop_front();
          if (want.ev == EV_PING) n_pings++;
          else n_ends++;
          if (event_res !== want.ev || ping_leader !== want.leader ||
              neighbor_count !== want.count || overflow !== want.ovf ||
              last !== want.last) begin
            err_count++;
            if (err_count <= 10) begin
              $display("mismatch exp: ev=%0b leader=%h cnt=%0d ovf=%0b last=%0b",
                       want.ev, want.leader, want.count, want.ovf, want.last);
              $display("         got: ev=%0b leader=%h cnt=%0d ovf=%0b last=%0b",
                       event_res, ping_leader, neighbor_count, overflow, last);
            end
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 20);
    end
  end

  // watchdog: no transfer on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("watchdog: no transfer for %0d cycles", quiet);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stim
    int r;
    int n;
    logic [AddrW-1:0] own;
    logic [IntervalW-1:0] iv;
    logic [TimeoutW-1:0] tmo;
    logic [AddrW-1:0] lead;
    logic [AddrW-1:0] snd;

    sender_pool[0] = '0;
    sender_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) sender_pool[i] = rand64();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: idle tick and pings, unused kind, first ping on first tick
    add_msg(KIND_TICK, '1, '1);
    add_msg(KIND_PING, '0, '0);
    add_msg(KIND_PING, '1, '1);
    add_msg(KIND_UNUSED, '1, '1);
    add_msg(KIND_START, '0, '0);
    add_msg(KIND_TICK, '0, '0);
    add_msg(KIND_PING, 64'd5, '0);
    add_msg(KIND_TICK, '0, '0);
    drain_all();

    // ping and phase end on the same tick
    set_regs('1, 16'd1, 20'd1);
    add_msg(KIND_START, '0, '0);
    add_msg(KIND_TICK, '0, '0);
    add_msg(KIND_TICK, '0, '0);
    add_msg(KIND_PING, 64'h8000_0000_0000_0000, sender_pool[2]);
    drain_all();

    // zero interval and timeout, restart while active
    set_regs('0, 16'd0, 20'd0);
    add_msg(KIND_START, '0, '0);
    add_msg(KIND_TICK, '0, '0);
    add_msg(KIND_START, '1, '1);
    add_msg(KIND_START, '0, '0);
    add_msg(KIND_TICK, '0, '0);
    drain_all();

    // largest interval and timeout
    set_regs(rand64(), 16'hFFFF, 20'hFFFFF);
    add_msg(KIND_START, '0, '0);
    add_msg(KIND_TICK, '0, '0);
    add_msg(KIND_TICK, '0, '0);
    add_msg(KIND_PING, '1, sender_pool[3]);
    add_msg(KIND_TICK, '0, '0);
    drain_all();

    while (n_items < ItemTarget) begin
      r = $urandom_range(0, 99);
      own = (r < 20) ? '0 : (r < 35) ? '1 : (rand64() >> $urandom_range(0, 40));
      r = $urandom_range(0, 99);
      iv = (r < 5) ? 16'hFFFF : (r < 10) ? 16'd1 : IntervalW'($urandom_range(1, 12));
      r = $urandom_range(0, 99);
      tmo = (r < 5) ? 20'hFFFFF : (r < 10) ? 20'd1 : TimeoutW'($urandom_range(3, 90));
      set_regs(own, iv, tmo);

      add_msg(KIND_START, rand64(), rand64());
      n = $urandom_range(60, 140);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 70 || r >= 97) begin
          add_msg((r < 70) ? KIND_TICK : KIND_UNUSED, rand64(), rand64());
        end else if (r < 91) begin
          if (n_items >= ItemTarget / 2 && $urandom_range(0, 9) < 7)
            snd = rand64();
          else
            snd = sender_pool[$urandom_range(0, PoolSize - 1)];
          r = $urandom_range(0, 19);
          lead = (r == 0) ? '1 : (r == 1) ? '0 : (rand64() >> $urandom_range(0, 63));
          add_msg(KIND_PING, lead, snd);
        end else begin
          add_msg(KIND_START, rand64(), rand64());
        end
      end
      drain_all();
    end

    $display("%0d transfers in, %0d pings and %0d phase ends checked",
             n_in, n_pings, n_ends);
    $display("neighbor table reached %0d entries, overflow %0b, %0d mismatches",
             nb_fill, nb_ovf, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
